[sv/flare_guidance_director_assert.svh]
// Assertion helpers for the flare guidance director.
`ifndef FLARE_GUIDANCE_DIRECTOR_ASSERT_SVH
`define FLARE_GUIDANCE_DIRECTOR_ASSERT_SVH

// Same-cycle implication.
`define FGD_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FGD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/fgd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package fgd_pkg;

  localparam int ALT_W   = 18;
  localparam int VS_W    = 15;
  localparam int GS_W    = 16;
  localparam int DEV_W   = 13;
  localparam int DT_W    = 16;
  localparam int FC_W    = 16;
  localparam int MSR_W   = 14;
  localparam int FRM_W   = 16;
  localparam int Q16_W   = 17;
  localparam int IN_W    = 80;
  localparam int OUT_W   = 120;
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;

  localparam int DIV_NUM_W = 35;
  localparam int DIV_DEN_W = 23;
  localparam int SQ_W      = 31;
  localparam int ROOT_W    = 17;

  localparam logic [20:0]    TWO_G_Q16        = 21'd1285377;
  localparam logic [FC_W-1:0] DEFAULT_GAIN    = 16'd6554;
  localparam logic [ALT_W-1:0] MIN_HEIGHT     = 18'd26;
  localparam logic [GS_W-1:0] MIN_GROUND      = 16'd26;
  localparam logic [ALT_W-1:0] TOUCH_ALT      = 18'd128;
  localparam logic [ROOT_W-1:0] MAX_CMD_MAG   = 17'd2560;
  localparam logic [Q16_W-1:0] ONE_Q16        = 17'd65536;
  localparam logic [17:0]    NOT_SINKING_TIME = 18'd255744;
  localparam logic [17:0]    SAT18            = 18'd262143;

  localparam logic [FC_W-1:0]  RST_FLARE_GAIN = 16'd0;
  localparam logic [ALT_W-1:0] RST_ACTIVATE   = 18'd6242;
  localparam logic [ALT_W-1:0] RST_FULL       = 18'd3901;
  localparam logic [ALT_W-1:0] RST_CANCEL     = 18'd7803;
  localparam logic [MSR_W-1:0] RST_MIN_SINK   = 14'd128;

  typedef enum logic [2:0] {
    REG_FLARE_GAIN = 3'd0,
    REG_ACTIVATE   = 3'd1,
    REG_FULL       = 3'd2,
    REG_CANCEL     = 3'd3,
    REG_MIN_SINK   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [FC_W-1:0]  flare_gain;
    logic [ALT_W-1:0] activate_altitude;
    logic [ALT_W-1:0] full_altitude;
    logic [ALT_W-1:0] cancel_altitude;
    logic [MSR_W-1:0] min_sink_rate;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic start;
    logic ramp;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic busy;
  } dp_status_t;

endpackage
`default_nettype wire

[sv/fgd_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module fgd_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [fgd_pkg::DIV_NUM_W-1:0]  num,
  input  logic [fgd_pkg::DIV_DEN_W-1:0]  den,
  output logic                           busy,
  output logic [fgd_pkg::DIV_NUM_W-1:0]  quo
);
  import fgd_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic [DIV_DEN_W:0]   rem_sh, rem_diff;
  logic                 ge;

  // one quotient bit per cycle, quotient shifts in behind the dividend
  always_comb begin
    rem_sh   = {rem_r, num_r[DIV_NUM_W-1]};
    ge       = rem_sh >= {1'b0, den_r};
    rem_diff = rem_sh - {1'b0, den_r};
    rem_nxt  = ge ? rem_diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
    num_nxt  = {num_r[DIV_NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      num_r  <= num;
      den_r  <= den;
      rem_r  <= '0;
      cnt_r  <= CNT_W'(DIV_NUM_W);
      busy_r <= 1'b1;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quo  = num_r;
endmodule
`default_nettype wire

[sv/fgd_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
module fgd_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [fgd_pkg::SQ_W-1:0]    rad,
  output logic                        busy,
  output logic [fgd_pkg::ROOT_W-1:0]  root
);
  import fgd_pkg::*;

  localparam int K_W = $clog2(SQ_W / 2 + 1);

  logic [SQ_W-1:0] x_r, x_nxt;
  logic [SQ_W-1:0] r_r, r_nxt;
  logic [K_W-1:0]  k_r;
  logic            busy_r;
  logic [SQ_W-1:0] bitv;
  logic [SQ_W:0]   trial;
  logic            ge;

  always_comb begin
    bitv  = SQ_W'(1) << {k_r, 1'b0};
    trial = {1'b0, r_r} + {1'b0, bitv};
    ge    = {1'b0, x_r} >= trial;
    x_nxt = ge ? SQ_W'({1'b0, x_r} - trial) : x_r;
    r_nxt = ge ? ((r_r >> 1) + bitv) : (r_r >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
    end else if (start) begin
      x_r    <= rad;
      r_r    <= '0;
      k_r    <= K_W'(SQ_W / 2);
      busy_r <= 1'b1;
    end else if (busy_r) begin
      x_r <= x_nxt;
      r_r <= r_nxt;
      if (k_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        k_r <= k_r - 1'b1;
      end
    end
  end

  // round to nearest: bump when the remainder exceeds the floor root
  assign root = ROOT_W'(r_r) + ROOT_W'(x_r > r_r);
  assign busy = busy_r;
endmodule
`default_nettype wire

[sv/fgd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module fgd_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  fgd_pkg::dp_status_t    status,
  output fgd_pkg::ctrl_cmd_t     cmd
);
  import fgd_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL1  = 7'b0000010,
    S_MUL2  = 7'b0000100,
    S_START = 7'b0001000,
    S_WAIT  = 7'b0010000,
    S_RAMP  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_START;
      end
      S_START: begin
        cmd.start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!status.busy) begin
          state_nxt = S_RAMP;
        end
      end
      S_RAMP: begin
        cmd.ramp  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
endmodule
`default_nettype wire

[sv/fgd_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module fgd_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fgd_pkg::cfg_t               cfg,
  input  fgd_pkg::ctrl_cmd_t          cmd,
  output fgd_pkg::dp_status_t         status,
  input  logic [fgd_pkg::IN_W-1:0]    in_data,
  output logic [fgd_pkg::OUT_W-1:0]   out_data
);
  import fgd_pkg::*;

  // reciprocal of 3 in Q19, exact for numerators below 2^19
  localparam logic [17:0] RECIP3       = 18'd174763;
  // reciprocal of 5 in Q16, exact for numerators below 2^14
  localparam logic [13:0] RECIP5       = 14'd13108;
  // frames*dt at or above this gives an anticipation of one
  localparam logic [31:0] ANT_FULL_FDT = 32'd98304;

  // unpacked input
  logic [18:0]      alt_raw;
  logic [ALT_W-1:0] alt_in;
  logic [VS_W-1:0]  vs_in;
  logic [GS_W-1:0]  gs_raw, gs_in;
  logic [DEV_W-1:0] dev_in;
  logic [DT_W-1:0]  dt_in;
  logic [15:0]      neg_min;
  logic             sink_ok;

  // frame state
  logic             engaged_r, td_r, full_r;
  logic [ALT_W-1:0] ea_r;
  logic [FRM_W-1:0] frames_r;
  logic             eng_a, td_a, full_a;
  logic [ALT_W-1:0] ea_a;
  logic [FRM_W-1:0] fr_a;

  // captured sample
  logic [ALT_W-1:0] alt_r;
  logic [VS_W-1:0]  vs_r;
  logic [GS_W-1:0]  gs_r;
  logic [DEV_W-1:0] dev_r;
  logic [DT_W-1:0]  dt_r;

  // multiply stages
  logic [ALT_W-1:0]  h;
  logic [FC_W-1:0]   fc;
  logic [33:0]       fch_r, gsalt_r;
  logic [31:0]       fdt_r;
  logic [54:0]       rad_full;
  logic [SQ_W-1:0]   rad_r;

  // iterative units
  logic [VS_W-1:0]       nv;
  logic [DEV_W-1:0]      dmag;
  logic [DIV_NUM_W-1:0]  n_rise, n_ttd, n_dist;
  logic [DIV_NUM_W-1:0]  q_rise, q_ttd, q_dist;
  logic                  b_rise, b_ttd, b_dist, b_sq;
  logic [ROOT_W-1:0]     root;

  // constant divides
  logic [17:0]      ant_n;
  logic [35:0]      ant_prod;
  logic [DEV_W-1:0] dev_m;
  logic [26:0]      dt_prod;
  logic [9:0]       dterm_c, dterm_r;

  // ramp and finish
  logic [Q16_W-1:0] ant_c, ant_r;
  logic [11:0]      mag_c;
  logic [28:0]      ramp_r;
  logic [11:0]      magr;
  logic [15:0]      cmd16, err16, vs16;
  logic [16:0]      sum17;
  logic [Q16_W-1:0] rise;
  logic [17:0]      ttd, td_dist;
  logic [VS_W-1:0]  tvs;
  logic [21:0]      alt10;
  logic [OUT_W-1:0] result;
  logic [OUT_W-1:0] out_r;

  always_comb begin
    alt_raw = in_data[18:0];
    alt_in  = alt_raw[18] ? '0 : alt_raw[17:0];
    vs_in   = in_data[33:19];
    gs_raw  = in_data[49:34];
    dev_in  = in_data[62:50];
    dt_in   = in_data[78:63];
    gs_in   = (gs_raw < MIN_GROUND) ? MIN_GROUND : gs_raw;
    neg_min = 16'(-{2'b00, cfg.min_sink_rate});
    sink_ok = $signed({vs_in[VS_W-1], vs_in}) < $signed(neg_min);
  end

  // engage, touchdown and cancel, in that order
  always_comb begin
    eng_a = engaged_r;
    ea_a  = ea_r;
    fr_a  = frames_r;
    td_a  = td_r;
    if (!engaged_r && alt_in <= cfg.activate_altitude && sink_ok) begin
      eng_a = 1'b1;
      ea_a  = alt_in;
      fr_a  = '0;
      td_a  = 1'b0;
    end
    if (eng_a && alt_in <= TOUCH_ALT) begin
      td_a = 1'b1;
    end
    if (eng_a && alt_in > cfg.cancel_altitude) begin
      eng_a = 1'b0;
      fr_a  = '0;
      td_a  = 1'b0;
    end
    full_a = eng_a && alt_in <= cfg.full_altitude;
    if (eng_a && fr_a != '1) begin
      fr_a = fr_a + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      engaged_r <= 1'b0;
      td_r      <= 1'b0;
      ea_r      <= '0;
      frames_r  <= '0;
    end else if (cmd.load) begin
      engaged_r <= eng_a;
      td_r      <= td_a;
      ea_r      <= ea_a;
      frames_r  <= fr_a;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      alt_r  <= alt_in;
      vs_r   <= vs_in;
      gs_r   <= gs_in;
      dev_r  <= dev_in;
      dt_r   <= dt_in;
      full_r <= full_a;
    end
  end

  always_comb begin
    h        = (alt_r < MIN_HEIGHT) ? MIN_HEIGHT : alt_r;
    fc       = (cfg.flare_gain == '0) ? DEFAULT_GAIN : cfg.flare_gain;
    rad_full = 55'(fch_r) * 55'(TWO_G_Q16);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      fch_r   <= 34'(fc) * 34'(h);
      gsalt_r <= 34'(gs_r) * 34'(alt_r);
      fdt_r   <= 32'(frames_r) * 32'(dt_r);
    end
    if (cmd.mul2) begin
      rad_r <= SQ_W'((rad_full + 55'd8388608) >> 24);
    end
  end

  always_comb begin
    nv     = VS_W'(-vs_r);
    dmag   = dev_r[DEV_W-1] ? DEV_W'(-dev_r) : dev_r;
    n_rise = DIV_NUM_W'({ALT_W'(ea_r - alt_r), 16'b0}) + DIV_NUM_W'(ea_r >> 1);
    n_ttd  = DIV_NUM_W'({alt_r, 8'b0}) + DIV_NUM_W'(nv >> 1);
    n_dist = DIV_NUM_W'(gsalt_r) + DIV_NUM_W'({nv, 7'b0});
  end

  fgd_div u_div_rise (
    .clk(clk), .rst_n(rst_n), .start(cmd.start), .num(n_rise),
    .den(DIV_DEN_W'(ea_r)), .busy(b_rise), .quo(q_rise)
  );
  fgd_div u_div_ttd (
    .clk(clk), .rst_n(rst_n), .start(cmd.start), .num(n_ttd),
    .den(DIV_DEN_W'(nv)), .busy(b_ttd), .quo(q_ttd)
  );
  fgd_div u_div_dist (
    .clk(clk), .rst_n(rst_n), .start(cmd.start), .num(n_dist),
    .den(DIV_DEN_W'({nv, 8'b0})), .busy(b_dist), .quo(q_dist)
  );
  fgd_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(cmd.start), .rad(rad_r),
    .busy(b_sq), .root(root)
  );

  assign status.busy = b_rise | b_ttd | b_dist | b_sq;

  // anticipation (2*frames*dt + 1) / 3 and deviation term (2*|dev| + 5) / 10
  always_comb begin
    ant_n    = {fdt_r[16:0], 1'b1};
    ant_prod = 36'(ant_n) * 36'(RECIP3);
    ant_c    = (fdt_r >= ANT_FULL_FDT) ? ONE_Q16 : Q16_W'(ant_prod >> 19);
    dev_m    = dmag + 13'd2;
    dt_prod  = 27'(dev_m) * 27'(RECIP5);
    dterm_c  = dt_prod[25:16];
    mag_c    = (root > MAX_CMD_MAG) ? MAX_CMD_MAG[11:0] : root[11:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ant_r   <= ant_c;
      dterm_r <= dterm_c;
    end
    if (cmd.ramp) begin
      ramp_r <= 29'(mag_c) * 29'(ant_r);
    end
  end

  always_comb begin
    magr  = 12'((ramp_r + 29'd32768) >> 16);
    cmd16 = dev_r[DEV_W-1] ? (16'(dterm_r) - 16'(magr)) : (-16'(magr) - 16'(dterm_r));
    vs16  = {vs_r[VS_W-1], vs_r};
    err16 = cmd16 - vs16;
    sum17 = {vs16[15], vs16} + {cmd16[15], cmd16};
    alt10 = {alt_r, 3'b0} + {3'b0, alt_r, 1'b0};

    if (ea_r >= MIN_HEIGHT) begin
      if (alt_r >= ea_r) begin
        rise = '0;
      end else begin
        rise = (q_rise > DIV_NUM_W'(ONE_Q16)) ? ONE_Q16 : q_rise[Q16_W-1:0];
      end
    end else begin
      rise = ONE_Q16;
    end

    if (vs_r[VS_W-1]) begin
      ttd     = (q_ttd > DIV_NUM_W'(SAT18)) ? SAT18 : q_ttd[17:0];
      td_dist = (q_dist > DIV_NUM_W'(SAT18)) ? SAT18 : q_dist[17:0];
      tvs     = (alt10 > 22'(nv)) ? sum17[15:1] : vs_r;
    end else begin
      ttd     = NOT_SINKING_TIME;
      td_dist = '0;
      tvs     = vs_r;
    end

    result = '0;
    if (engaged_r) begin
      result[0]       = 1'b1;
      result[1]       = full_r;
      result[2]       = td_r;
      result[17:3]    = cmd16[14:0];
      result[33:18]   = err16;
      result[50:34]   = rise;
      result[67:51]   = ant_r;
      result[85:68]   = ttd;
      result[103:86]  = td_dist;
      result[118:104] = tvs;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r <= result;
    end
  end

  assign out_data = out_r;
endmodule
`default_nettype wire

[sv/flare_guidance_director.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "flare_guidance_director_assert.svh"
// Flare guidance director: one display-frame sample in, one guidance result out.
// The input transfer is followed by two multiply stages and the start of the iterative
// units; three bit-serial dividers then run side by side with a 16-step square root
// (the 35 divide steps set the length), then come a ramp multiply and the output load.
// A result left waiting holds the output load and with it the next sample.
// The next sample is taken as soon as the result sits in the output register, even
// if it has not been taken yet.
// No clearing pass follows reset. Registers sit at byte addresses 0, 4, 8, 12
// and 16 (flare_gain, activate_altitude, full_altitude, cancel_altitude,
// min_sink_rate); write them only while no sample is in flight.
module flare_guidance_director (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // radio_altitude[18:0], vertical_speed[33:19], ground_speed[49:34],
  // glideslope_deviation[62:50], frame_time[78:63], zero pad [79]
  input  logic [fgd_pkg::IN_W-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // active[0], fully_active[1], complete[2], command_sink[17:3],
  // command_error[33:18], cue_rise[50:34], anticipation[67:51],
  // time_to_touchdown[85:68], touchdown_distance[103:86],
  // touchdown_sink[118:104], zero pad [119]
  output logic [fgd_pkg::OUT_W-1:0]     out_tdata,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [fgd_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [fgd_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [fgd_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import fgd_pkg::*;

  cfg_t       cfg_r;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flare_gain        <= RST_FLARE_GAIN;
      cfg_r.activate_altitude <= RST_ACTIVATE;
      cfg_r.full_altitude     <= RST_FULL;
      cfg_r.cancel_altitude   <= RST_CANCEL;
      cfg_r.min_sink_rate     <= RST_MIN_SINK;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_FLARE_GAIN: cfg_r.flare_gain        <= cfg_pwdata[FC_W-1:0];
        REG_ACTIVATE:   cfg_r.activate_altitude <= cfg_pwdata[ALT_W-1:0];
        REG_FULL:       cfg_r.full_altitude     <= cfg_pwdata[ALT_W-1:0];
        REG_CANCEL:     cfg_r.cancel_altitude   <= cfg_pwdata[ALT_W-1:0];
        REG_MIN_SINK:   cfg_r.min_sink_rate     <= cfg_pwdata[MSR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_FLARE_GAIN: cfg_prdata = CFG_DW'(cfg_r.flare_gain);
      REG_ACTIVATE:   cfg_prdata = CFG_DW'(cfg_r.activate_altitude);
      REG_FULL:       cfg_prdata = CFG_DW'(cfg_r.full_altitude);
      REG_CANCEL:     cfg_prdata = CFG_DW'(cfg_r.cancel_altitude);
      REG_MIN_SINK:   cfg_prdata = CFG_DW'(cfg_r.min_sink_rate);
      default:        cfg_prdata = '0;
    endcase
  end

  fgd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .status(status), .cmd(cmd)
  );

  fgd_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .cmd(cmd), .status(status),
    .in_data(in_tdata), .out_data(out_tdata)
  );

  `FGD_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready, "sample taken while busy")
  `FGD_ASSERT_IMPL(a_idle_zero, clk, rst_n, out_tvalid && !out_tdata[0], out_tdata[118:1] == '0, "inactive result not zero")
  `FGD_ASSERT_IMPL(a_flags_active, clk, rst_n, out_tvalid && (out_tdata[1] || out_tdata[2]), out_tdata[0], "flag without active")
  `FGD_ASSERT_IMPL(a_ant_cap, clk, rst_n, out_tvalid, out_tdata[67:51] <= 17'd65536, "anticipation above one")
endmodule
`default_nettype wire

[tb/flare_guidance_director_tb.sv]
`timescale 1ns / 1ps
module flare_guidance_director_tb;
  import fgd_pkg::*;

  localparam logic [CFG_AW-1:0] UNUSED_ADDR = 5'd28;
  localparam int QUIET_ITEMS = 150;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    int alt;
    int vs;
    int gs;
    int dev;
    int dt;
    bit idle_frame;
  } frame_row_t;

  typedef struct packed {
    logic [15:0]         dt;
    logic signed [12:0]  dev;
    logic [15:0]         gs;
    logic signed [14:0]  vs;
    logic signed [18:0]  alt;
  } frame_t;

  typedef struct packed {
    logic [14:0] td_sink;
    logic [17:0] td_dist;
    logic [17:0] td_time;
    logic [16:0] anticip;
    logic [16:0] rise;
    logic [15:0] cmd_err;
    logic [14:0] cmd_sink;
    logic        complete;
    logic        full;
    logic        active;
  } guidance_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  flare_guidance_director dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #10 clk = ~clk;

  // Shadow registers and guidance state
  longint unsigned gain_r, activate_r, full_r, cancel_r, min_sink_r;
  bit engaged_s, touchdown_s;
  longint unsigned engage_alt_s, frames_s;

  guidance_t pending_results[$];
  int errors = 0;
  bit quiet = 1'b0;

  frame_row_t dir_rows [15] = '{
    '{262143, 0, 0, 0, 0, 1'b1},
    '{6242, -128, 100, 0, 1092, 1'b1},
    '{6242, -129, 0, 0, 1092, 1'b0},
    '{6000, -300, 65535, 4095, 65535, 1'b0},
    '{3901, -300, 5000, -4096, 65535, 1'b0},
    '{1000, 300, 5000, 10, 1092, 1'b0},
    '{128, -16384, 5000, 0, 1092, 1'b0},
    '{-262144, -16384, 25, -1, 65535, 1'b0},
    '{20, -1, 5000, 0, 1092, 1'b0},
    '{0, -1, 5000, 0, 1092, 1'b0},
    '{7803, 16383, 5000, 0, 1092, 1'b0},
    '{7804, -500, 5000, 0, 1092, 1'b1},
    '{20, -200, 5000, 3, 1092, 1'b0},
    '{20, -200, 5000, -3, 0, 1'b0},
    '{262143, -16384, 65535, 0, 65535, 1'b1}
  };

  function automatic longint unsigned root_nearest(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (x > r) r++;
    return r;
  endfunction

  function automatic longint unsigned div_round_sat(longint unsigned num, longint unsigned den,
                                                    longint unsigned cap);
    longint unsigned q;
    q = (num + den / 2) / den;
    return (q > cap) ? cap : q;
  endfunction

  function automatic guidance_t predict_guidance(frame_t f);
    longint alt, vs, dev, cmd, dterm, tvs;
    longint unsigned gs, dt, h, fc, rad, mag, ant, nv;
    guidance_t r;
    bit full;
    r = '0;
    alt = $signed(f.alt);
    if (alt < 0) alt = 0;
    vs = $signed(f.vs);
    dev = $signed(f.dev);
    gs = f.gs;
    if (gs < MIN_GROUND) gs = MIN_GROUND;
    dt = f.dt;

    if (!engaged_s && alt <= activate_r && vs < -longint'(min_sink_r)) begin
      engaged_s = 1'b1;
      engage_alt_s = alt;
      frames_s = 0;
      touchdown_s = 1'b0;
    end
    if (engaged_s && alt <= TOUCH_ALT) touchdown_s = 1'b1;
    if (engaged_s && alt > cancel_r) begin
      engaged_s = 1'b0;
      frames_s = 0;
      touchdown_s = 1'b0;
    end
    full = engaged_s && alt <= full_r;
    if (!engaged_s) return r;
    if (frames_s < 65535) frames_s++;

    h = (alt < MIN_HEIGHT) ? MIN_HEIGHT : alt;
    fc = (gain_r != 0) ? gain_r : DEFAULT_GAIN;
    rad = (TWO_G_Q16 * fc * h + (64'd1 << 23)) >> 24;
    mag = root_nearest(rad);
    if (mag > MAX_CMD_MAG) mag = MAX_CMD_MAG;
    ant = (2 * frames_s * dt + 1) / 3;
    if (ant > ONE_Q16) ant = ONE_Q16;
    mag = (mag * ant + 32768) >> 16;
    dterm = (2 * ((dev < 0) ? -dev : dev) + 5) / 10;
    if (dev < 0) dterm = -dterm;
    cmd = -longint'(mag) - dterm;
    if (cmd > 16383) cmd = 16383;
    if (cmd < -16384) cmd = -16384;

    r.active = 1'b1;
    r.full = full;
    r.complete = touchdown_s;
    r.cmd_sink = cmd[14:0];
    r.cmd_err = 16'(cmd - vs);
    r.anticip = ant[16:0];
    if (engage_alt_s >= MIN_HEIGHT) begin
      if (alt >= engage_alt_s) r.rise = '0;
      else r.rise = 17'(div_round_sat((engage_alt_s - alt) << 16, engage_alt_s, ONE_Q16));
    end else begin
      r.rise = ONE_Q16;
    end
    if (vs < 0) begin
      nv = -vs;
      r.td_time = 18'(div_round_sat(alt << 8, nv, SAT18));
      r.td_dist = 18'(div_round_sat(gs * alt, nv << 8, SAT18));
      tvs = (10 * alt > nv) ? ((vs + cmd) >>> 1) : vs;
    end else begin
      r.td_time = NOT_SINKING_TIME;
      r.td_dist = '0;
      tvs = vs;
    end
    r.td_sink = tvs[14:0];
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  // Result side: compare every transfer with the oldest expectation
  always @(posedge clk) begin
    guidance_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[OUT_W-2:0];
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %h", $realtime, out_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("active", want.active, got.active);
        check_field("fully_active", want.full, got.full);
        check_field("complete", want.complete, got.complete);
        check_field("command_sink", want.cmd_sink, got.cmd_sink);
        check_field("command_error", want.cmd_err, got.cmd_err);
        check_field("cue_rise", want.rise, got.rise);
        check_field("anticipation", want.anticip, got.anticip);
        check_field("time_to_touchdown", want.td_time, got.td_time);
        check_field("touchdown_distance", want.td_dist, got.td_dist);
        check_field("touchdown_sink", want.td_sink, got.td_sink);
        check_field("pad", 0, out_tdata[OUT_W-1]);
      end
    end
  end

  // Receiver stalls in bursts
  always @(negedge clk) begin
    int stall;
    if (quiet || !rst_n) begin
      out_tready <= rst_n;
      stall = 0;
    end else if (stall > 0) begin
      stall--;
      out_tready <= 1'b0;
    end else if ($urandom_range(3) == 0) begin
      stall = $urandom_range(6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic write_reg(logic [CFG_AW-1:0] addr, longint unsigned value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value[31:0];
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (addr)
      CFG_AW'(REG_FLARE_GAIN * 4): gain_r = value & 64'hFFFF;
      CFG_AW'(REG_ACTIVATE * 4):   activate_r = value & 64'h3FFFF;
      CFG_AW'(REG_FULL * 4):       full_r = value & 64'h3FFFF;
      CFG_AW'(REG_CANCEL * 4):     cancel_r = value & 64'h3FFFF;
      CFG_AW'(REG_MIN_SINK * 4):   min_sink_r = value & 64'h3FFF;
      default: ;
    endcase
  endtask

  task automatic set_limits(longint unsigned gain, longint unsigned act, longint unsigned fl,
                            longint unsigned cn, longint unsigned ms);
    write_reg(CFG_AW'(REG_FLARE_GAIN * 4), gain);
    write_reg(CFG_AW'(REG_ACTIVATE * 4), act);
    write_reg(CFG_AW'(REG_FULL * 4), fl);
    write_reg(CFG_AW'(REG_CANCEL * 4), cn);
    write_reg(CFG_AW'(REG_MIN_SINK * 4), ms);
  endtask

  // Hold the sender until every result is back, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_frame(frame_t f, bit idle_frame);
    guidance_t want;
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(3) == 0) begin
      gap = $urandom_range(7, 1);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, f};
    do @(posedge clk); while (!in_tready);
    want = predict_guidance(f);
    if (idle_frame) want = '0;
    pending_results.push_back(want);
  endtask

  task automatic send_random(int count, int quiet_from);
    frame_t f;
    logic [95:0] noise;
    longint alt, vs, dt;
    int n, len;
    n = 0;
    while (n < count) begin
      if ($urandom_range(4) == 0) begin
        // noise over the whole field ranges
        noise = {$urandom, $urandom, $urandom};
        f = noise[IN_W-2:0];
        quiet = (n >= quiet_from);
        send_frame(f, 1'b0);
        n++;
      end else begin
        // approach: descend through the engage window toward touchdown
        alt = $urandom_range(activate_r + 1500 > 262143 ? 262143 : activate_r + 1500);
        vs = -longint'($urandom_range(2500, 40));
        dt = ($urandom_range(1)) ? 1092 : $urandom_range(65535);
        len = $urandom_range(60, 8);
        for (int k = 0; k < len && n < count; k++) begin
          if ($urandom_range(15) == 0) vs = longint'($urandom_range(3000)) - 1000;
          f.alt = 19'(alt);
          f.vs = 15'(vs);
          f.gs = 16'($urandom_range(20000));
          f.dev = 13'(int'($urandom_range(800)) - 400);
          f.dt = 16'(dt);
          quiet = (n >= quiet_from);
          send_frame(f, 1'b0);
          n++;
          alt = alt + ((vs * dt) >>> 16) + int'($urandom_range(20)) - 10;
          if (alt < -50) alt = -50;
          if (alt > 262143) alt = 262143;
        end
      end
    end
  endtask

  initial begin
    frame_t f;
    gain_r = 0;
    activate_r = RST_ACTIVATE;
    full_r = RST_FULL;
    cancel_r = RST_CANCEL;
    min_sink_r = RST_MIN_SINK;
    engaged_s = 1'b0;
    touchdown_s = 1'b0;
    engage_alt_s = 0;
    frames_s = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      f.alt = 19'(dir_rows[i].alt);
      f.vs = 15'(dir_rows[i].vs);
      f.gs = 16'(dir_rows[i].gs);
      f.dev = 13'(dir_rows[i].dev);
      f.dt = 16'(dir_rows[i].dt);
      send_frame(f, dir_rows[i].idle_frame);
    end
    send_random(300, 300);
    drain();

    set_limits(65535, 262143, 262143, 262143, 0);
    write_reg(UNUSED_ADDR, 32'hFFFF_FFFF);
    send_random(250, 250);
    drain();

    set_limits(0, 0, 0, 0, 16383);
    send_random(150, 150);
    drain();

    for (int p = 0; p < 3; p++) begin
      set_limits($urandom_range(65535), $urandom_range(20000, 500), $urandom_range(8000),
                 $urandom_range(30000, 4000), $urandom_range(400));
      send_random(200, 200);
      drain();
    end

    set_limits(6554, 6242, 3901, 7803, 128);
    send_random(300, 300 - QUIET_ITEMS);
    drain();

    if (errors == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/fgd_pkg.sv
sv/fgd_div.sv
sv/fgd_sqrt.sv
sv/fgd_ctrl.sv
sv/fgd_datapath.sv
sv/flare_guidance_director.sv
tb/flare_guidance_director_tb.sv
